// File: hdl/ztp_pkg.sv
// ----------------------------------------------------------------------------
// ztp_pkg
// Shared types and constants of the Z-order tile partitioner.
// ----------------------------------------------------------------------------
package ztp_pkg;

  localparam int ID_W     = 64;
  localparam int OFF_W    = 48;
  localparam int BYTES_W  = 32;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 32;
  localparam int NDIM_W   = 3;
  localparam int EDGE_W   = 16;
  localparam int EB_W     = 13;
  localparam int MAXD     = 4;

  localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [2:0] REG_TILE_EDGE  = 3'd1;
  localparam logic [2:0] REG_ELEM_BYTES = 3'd2;
  localparam logic [2:0] REG_EXTENT_0   = 3'd3;
  localparam logic [2:0] REG_EXTENT_3   = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture id, start decode
    logic div_start; // start the divide of the current dimension
    logic dim_step;  // fold the current dimension into offset and size
    logic dim_next;  // move to next dimension
  } ztp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic div_done;
    logic outside;   // current coordinate beyond block count
    logic last_dim;
  } ztp_sts_t;

endpackage

// File: hdl/ztp_datapath.sv
// ----------------------------------------------------------------------------
// ztp_datapath
// Morton decode, per-dimension block count by restoring divide, offset and
// size accumulation, one dimension at a time.
// ----------------------------------------------------------------------------
module ztp_datapath import ztp_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int CLUSTER_BITS = 2,
  parameter int EXTENT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ztp_cmd_t             cmd,
  output ztp_sts_t             sts,
  input  logic [ID_W-1:0]      id_in,
  input  logic [NDIM_W-1:0]    num_dims,
  input  logic [EDGE_W-1:0]    tile_edge,
  input  logic [EB_W-1:0]      elem_bytes,
  input  logic [LEN_W-1:0]     extent [MAXD],
  output logic [OFF_W-1:0]     offset_o,
  output logic [BYTES_W-1:0]   bytes_o,
  output logic [LEN_W-1:0]     lens_o [MAXD],
  output logic [CNT_W-1:0]     cluster_o,
  output logic [1:0]           block_o,
  output logic [63:0]          nblocks_o
);

  localparam int CAP = (MAX_DIMS < 4) ? MAX_DIMS : 4;
  localparam logic [OFF_W-1:0]   OFF_MAX   = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   coord_r [MAXD];
  logic [1:0]        dim_r;
  logic [2:0]        nd;
  logic [EDGE_W-1:0] edge_v;
  logic [LEN_W-1:0]  ext;
  // restoring divider: ext+edge-1 (17 bits) by edge
  logic [16:0]       quo_r, rem_r, dvd_r;
  logic [4:0]        dcnt_r;
  logic              dbusy_r, ddone_r;
  logic [OFF_W-1:0]  off_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [63:0]       nblk_r;
  logic [LEN_W-1:0]  lens_r [MAXD];

  always_comb begin
    nd = (num_dims == 3'd0) ? 3'd1 : num_dims;
    if (nd > 3'(CAP)) nd = 3'(CAP);
    edge_v = (tile_edge == '0) ? EDGE_W'(1) : tile_edge;
    ext = (EXTENT_BITS >= 16) ? extent[dim_r]
        : (extent[dim_r] & LEN_W'((32'd1 << EXTENT_BITS) - 1));
  end

  // Morton de-interleave as a function of id and dimension count.
  function automatic logic [ID_W-1:0] decode(input logic [ID_W-1:0] id,
                                             input logic [2:0] n, input int d);
    logic [ID_W-1:0] c;
    c = '0;
    for (int i = 0; i < ID_W; i++) begin
      if (n == 3'd1 && d == 0) c[i] = id[i];
      if (n == 3'd2 && (i % 2) == d) c[i/2] = id[i];
      if (n == 3'd3 && (i % 3) == d) c[i/3] = id[i];
      if (n == 3'd4 && (i % 4) == d) c[i/4] = id[i];
    end
    return c;
  endfunction

  logic [17:0] trial;
  always_comb trial = {rem_r, dvd_r[16]} - {2'b0, edge_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= 5'd0;
        dvd_r   <= {1'b0, ext} + 17'(edge_v) - 17'd1;
        rem_r   <= '0;
        quo_r   <= '0;
      end else if (dbusy_r) begin
        if (!trial[17]) rem_r <= trial[16:0];
        else            rem_r <= {rem_r[15:0], dvd_r[16]};
        quo_r <= {quo_r[15:0], ~trial[17]};
        dvd_r <= {dvd_r[15:0], 1'b0};
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd16) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end

  // Per-dimension terms once the block count is known.
  logic [63:0] cd;
  logic [63:0] origin;
  logic [96:0] offmul;
  logic [63:0] offn;
  logic [LEN_W-1:0] len;
  logic [47:0] bmul;
  logic [63:0] nbmul;

  always_comb begin
    cd = coord_r[dim_r];
    origin = {31'd0, 33'(cd[16:0]) * 33'(edge_v)};
    if (cd[63:17] != '0) origin = '1;
    offmul = off_r * ext;
    if (dim_r == 2'd0) offn = origin;
    else if (off_r != '0 && ext != '0 && offmul > 97'(OFF_MAX)) offn = 64'(OFF_MAX);
    else offn = offmul[63:0] + origin;
    if (offn > 64'(OFF_MAX)) offn = 64'(OFF_MAX);
    // On the last block the clipped length is the divide remainder plus one.
    if (cd == 64'(quo_r) - 64'd1)
      len = rem_r[LEN_W-1:0] + LEN_W'(1);
    else len = edge_v;
    bmul = bytes_r * len;
    nbmul = nblk_r * 64'(quo_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r <= id_in;
      for (int d = 0; d < MAXD; d++) begin
        coord_r[d] <= decode(id_in, nd, d);
        lens_r[d] <= '0;
      end
      dim_r   <= 2'd0;
      off_r   <= '0;
      bytes_r <= 32'(elem_bytes);
      nblk_r  <= 64'd1;
    end else begin
      if (cmd.dim_step) begin
        off_r <= offn[OFF_W-1:0];
        lens_r[dim_r] <= len;
        bytes_r <= (bmul > 48'(BYTES_MAX)) ? BYTES_MAX : bmul[31:0];
        nblk_r <= nbmul;
      end
      if (cmd.dim_next) dim_r <= dim_r + 2'd1;
    end
  end

  always_comb begin
    sts.div_done = ddone_r;
    sts.outside  = cd >= 64'(quo_r);
    sts.last_dim = (3'(dim_r) + 3'd1) >= nd;
    offset_o  = off_r;
    bytes_o   = bytes_r;
    lens_o    = lens_r;
    cluster_o = CNT_W'(id_r >> CLUSTER_BITS);
    block_o   = (CLUSTER_BITS == 0) ? 2'd0
              : 2'(id_r & ((ID_W'(1) << CLUSTER_BITS) - ID_W'(1)));
    nblocks_o = nblk_r;
  end

endmodule

// File: hdl/ztp_ctrl.sv
// ----------------------------------------------------------------------------
// ztp_ctrl
// Sequencer: one dimension per divide, then result hand-off.
// ----------------------------------------------------------------------------
module ztp_ctrl import ztp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  ztp_sts_t sts,
  output ztp_cmd_t cmd,
  output logic     busy,
  output logic     emit
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_WAIT, S_STEP, S_EMIT} state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else begin
      case (state_r)
        S_IDLE: if (in_fire) state_r <= S_DIV;
        S_DIV:  state_r <= S_WAIT;
        S_WAIT: if (sts.div_done) begin
          if (sts.outside) state_r <= S_IDLE;
          else state_r <= S_STEP;
        end
        S_STEP: state_r <= sts.last_dim ? S_EMIT : S_DIV;
        S_EMIT: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.load      = in_fire;
    cmd.div_start = (state_r == S_DIV);
    cmd.dim_step  = (state_r == S_STEP);
    cmd.dim_next  = (state_r == S_STEP) && !sts.last_dim;
    busy          = (state_r != S_IDLE);
    emit          = (state_r == S_EMIT) && out_free;
  end

endmodule

// File: hdl/zorder_tile_partitioner.sv
// ----------------------------------------------------------------------------
// zorder_tile_partitioner
// Channel | dir | content
// in_     | in  | tdata: Morton key
// out_    | out | tdata: partition result fields
// cfg_    | in  | register index and write data
// An id is handled one used dimension at a time, each dimension waiting on the
// 17-step restoring divider that computes its block count; an id outside the
// array ends at the dimension that rejects it.
// Reset is synchronous and restores the partition counter and the registers.
// Output is held in a register; a new id is taken once the last result has
// moved into it, so a stalled output blocks only the next emission.
// ----------------------------------------------------------------------------
module zorder_tile_partitioner import ztp_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int CLUSTER_BITS = 2,
  parameter int EXTENT_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // morton key [63:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // part_index[31:0], grp_idx[63:32], sub_idx[65:64], elem_offset[113:66],
  // tile_len_0..3[177:114], tile_bytes[209:178], overflow[210], zero pad
  output logic [215:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [NDIM_W-1:0] num_dims_r;
  logic [EDGE_W-1:0] tile_edge_r;
  logic [EB_W-1:0]   elem_bytes_r;
  logic [LEN_W-1:0]  extent_r [MAXD];
  logic [CNT_W-1:0]  count_r;
  logic              ovalid_r;
  logic [215:0]      odata_r;

  ztp_cmd_t cmd;
  ztp_sts_t sts;
  logic busy, emit, in_fire, out_free;
  logic [OFF_W-1:0]   offset;
  logic [BYTES_W-1:0] bytes;
  logic [LEN_W-1:0]   lens [MAXD];
  logic [CNT_W-1:0]   cluster;
  logic [1:0]         blk;
  logic [63:0]        nblocks;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r   <= 3'd1;
      tile_edge_r  <= 16'd1;
      elem_bytes_r <= 13'd1;
      for (int d = 0; d < MAXD; d++) extent_r[d] <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_DIMS:   num_dims_r   <= cfg_data[2:0];
        REG_TILE_EDGE:  tile_edge_r  <= cfg_data;
        REG_ELEM_BYTES: elem_bytes_r <= cfg_data[12:0];
        default: if (cfg_index >= REG_EXTENT_0 && cfg_index <= REG_EXTENT_3)
          extent_r[2'(cfg_index - REG_EXTENT_0)] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      if (emit) begin
        ovalid_r <= 1'b1;
        count_r  <= count_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit)
      odata_r <= {5'd0, (64'(count_r) >= nblocks), bytes, lens[3], lens[2],
                  lens[1], lens[0], offset, blk, cluster, count_r};
  end

  ztp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy), .emit(emit)
  );

  ztp_datapath #(.MAX_DIMS(MAX_DIMS), .CLUSTER_BITS(CLUSTER_BITS),
                 .EXTENT_BITS(EXTENT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .id_in(in_tdata),
    .num_dims(num_dims_r), .tile_edge(tile_edge_r), .elem_bytes(elem_bytes_r),
    .extent(extent_r), .offset_o(offset), .bytes_o(bytes), .lens_o(lens),
    .cluster_o(cluster), .block_o(blk), .nblocks_o(nblocks)
  );

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> count_r == $past(count_r) + 32'd1) else $error("count step");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result lost");
  a_nocap: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("accept while busy");

endmodule
